// ----- design/lcfs_pkg.sv -----
// Package for the LED chain frame serializer.
// Holds command, lane and register codes, the per-lane channel table, the
// sequencer phase type and the result struct. No dependencies.
`timescale 1ns / 1ps

package lcfs_pkg;

	localparam int CHANS_PER_CHIP = 12;

	// word position within one chip: 0 is the command word, 1..12 channels
	localparam logic [3:0] WORD_POS_LAST = 4'd12;

	localparam logic [15:0] LATCH_LOW_RST  = 16'd240;
	localparam logic [7:0]  LATCH_TAIL_RST = 8'd1;

	typedef enum logic [2:0] {
		CMD_WRITE   = 3'd0,
		CMD_CLEAR   = 3'd1,
		CMD_REFRESH = 3'd2,
		CMD_INIT    = 3'd3,
		CMD_TICK    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		LANE_COL_A = 3'd0,
		LANE_COL_B = 3'd1,
		LANE_RED   = 3'd2,
		LANE_GREEN = 3'd3,
		LANE_BLUE  = 3'd4
	} lane_t;

	localparam logic CFG_LATCH_LOW  = 1'b0;
	localparam logic CFG_LATCH_TAIL = 1'b1;

	typedef enum logic [7:0] {
		PH_IDLE   = 8'b0000_0001,
		PH_CLEAR  = 8'b0000_0010,
		PH_SHIFT  = 8'b0000_0100,
		PH_BLANK  = 8'b0000_1000,
		PH_LSTART = 8'b0001_0000,
		PH_LWAIT  = 8'b0010_0000,
		PH_LPULSE = 8'b0100_0000,
		PH_TAIL   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic pin_clk;
		logic pin_data;
		logic busy;
		logic error;
	} res_t;

	// channel offset within a 60-channel block, per lane and row-in-block
	localparam logic [5:0] LANE_MAP [5][12] = '{
		'{6'd8,  6'd5, 6'd1,  6'd17, 6'd35, 6'd31, 6'd25, 6'd45, 6'd39, 6'd58, 6'd53, 6'd48},
		'{6'd9,  6'd6, 6'd21, 6'd16, 6'd12, 6'd30, 6'd29, 6'd44, 6'd43, 6'd38, 6'd57, 6'd52},
		'{6'd10, 6'd3, 6'd23, 6'd19, 6'd14, 6'd33, 6'd27, 6'd47, 6'd41, 6'd36, 6'd55, 6'd50},
		'{6'd7,  6'd4, 6'd22, 6'd20, 6'd13, 6'd34, 6'd26, 6'd24, 6'd40, 6'd37, 6'd54, 6'd51},
		'{6'd11, 6'd2, 6'd0,  6'd18, 6'd15, 6'd32, 6'd28, 6'd46, 6'd42, 6'd59, 6'd56, 6'd49}
	};

	// store address of a write: (row/12)*60 + LANE_MAP; lane must be <= LANE_BLUE
	function automatic logic [8:0] write_addr(input logic [2:0] lane, input logic [5:0] row);
		logic [11:0] prod;
		logic [2:0]  blk;
		logic [5:0]  rem;
		prod = 12'(row) * 12'd43;      // 43/512 is exact enough for row/12 over 0..63
		blk  = prod[11:9];
		rem  = row - 6'(6'(blk) * 6'd12);
		return 9'(9'(blk) * 9'd60) + 9'(LANE_MAP[lane][rem[3:0]]);
	endfunction

endpackage

// ----- design/led_chain_frame_serializer.sv -----
// Top level of the LED chain frame serializer: request register, result
// register, configuration registers, sequencer and frame store.
// Depends on lcfs_pkg, lcfs_seq and lcfs_store.
`timescale 1ns / 1ps

// Takes one request per clock while req_stall is low and returns one result
// per request: the request is registered, then decoded and applied to the
// sequencer state in one pass that loads the result register.
// Each tick request moves the serial pins one step, so a full refresh takes
// NUM_CHIPS*13*32 ticks plus the latch. After reset the frame store is zeroed
// by a pass over all NUM_CHANNELS entries, during which req_stall stays high;
// configuration writes are taken at any time. Write latch registers only
// while the block is idle.
module led_chain_frame_serializer import lcfs_pkg::*; #(
	parameter int NUM_CHIPS    = 20,
	parameter int NUM_CHANNELS = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  cmd,
	input  logic [2:0]  lane,
	input  logic [5:0]  row,
	input  logic [15:0] value,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        pin_clk,
	output logic        pin_data,
	output logic        busy_res,
	output logic        error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = $clog2(NUM_CHANNELS);
	localparam int CW = $clog2(NUM_CHIPS);
	localparam int RW = $clog2(NUM_CHIPS * CHANS_PER_CHIP);

	logic          valid_s1;
	logic [2:0]    cmd_s1;
	logic [2:0]    lane_s1;
	logic [5:0]    row_s1;
	logic [15:0]   value_s1;
	logic          res_valid_q;
	res_t          res_q;
	res_t          res_d;
	logic [15:0]   latch_low_q;
	logic [7:0]    latch_tail_q;
	logic          go;
	logic          accept;
	logic          boot_clear;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata;

	assign go        = valid_s1 && (!res_valid_q || !res_stall);
	assign req_stall = boot_clear || (valid_s1 && !go);
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_q  <= 1'b0;
			latch_low_q  <= LATCH_LOW_RST;
			latch_tail_q <= LATCH_TAIL_RST;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (go) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_LATCH_LOW:  latch_low_q  <= cfg_data;
					CFG_LATCH_TAIL: latch_tail_q <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd;
			lane_s1  <= lane;
			row_s1   <= row;
			value_s1 <= value;
		end
		if (go) begin
			res_q <= res_d;
		end
	end

	lcfs_seq #(
		.NUM_CHIPS    (NUM_CHIPS),
		.NUM_CHANNELS (NUM_CHANNELS),
		.AW           (AW),
		.CW           (CW),
		.RW           (RW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.cmd        (cmd_s1),
		.lane       (lane_s1),
		.row        (row_s1),
		.value      (value_s1),
		.latch_low  (latch_low_q),
		.latch_tail (latch_tail_q),
		.res        (res_d),
		.boot_clear (boot_clear),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	lcfs_store #(
		.DEPTH (NUM_CHANNELS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign res_valid = res_valid_q;
	assign pin_clk   = res_q.pin_clk;
	assign pin_data  = res_q.pin_data;
	assign busy_res  = res_q.busy;
	assign error     = res_q.error;

endmodule

// ----- design/lcfs_store.sv -----
// Frame store memory: one write port, one registered read port.
// Uses no package.
`timescale 1ns / 1ps

module lcfs_store #(
	parameter int DEPTH = 240,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/lcfs_seq.sv -----
// Command decode and pin sequencer: write, clear, refresh shift, blank
// clocks and latch. Drives the frame store ports. Depends on lcfs_pkg.
`timescale 1ns / 1ps

module lcfs_seq import lcfs_pkg::*; #(
	parameter int NUM_CHIPS    = 20,
	parameter int NUM_CHANNELS = 240,
	parameter int AW           = 8,
	parameter int CW           = 5,
	parameter int RW           = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [2:0]    cmd,
	input  logic [2:0]    lane,
	input  logic [5:0]    row,
	input  logic [15:0]   value,
	input  logic [15:0]   latch_low,
	input  logic [7:0]    latch_tail,
	output res_t          res,
	output logic          boot_clear,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [15:0]   mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [15:0]   mem_rdata
);

	localparam logic [15:0] BLANK_PULSES = 16'((NUM_CHIPS + NUM_CHANNELS) * 8);
	localparam logic [AW-1:0] CLR_LAST = AW'(NUM_CHANNELS - 1);
	localparam logic [CW-1:0] CHIP_FIRST = CW'(NUM_CHIPS - 1);

	phase_t        phase_q, phase_d;
	logic          boot_q;
	logic [AW-1:0] clr_idx_q, clr_idx_d;
	logic [CW-1:0] chip_q, chip_d;
	logic [3:0]    pos_q, pos_d;
	logic [2:0]    pair_q, pair_d;
	logic [1:0]    sub_q, sub_d;
	logic [15:0]   wait_q, wait_d, wait_dec;
	logic [15:0]   shift_q, shift_d;
	logic          clk_lv_q, clk_lv_d;
	logic          data_lv_q, data_lv_d;
	logic          rd_ok_q;
	logic          rd_ok;
	logic [RW-1:0] rd_addr;
	logic [8:0]    wr_addr;
	logic          busy;
	logic          busy_reject;
	logic          err;
	logic          we_item;

	// address of the word after the current one in this chip
	assign rd_addr = RW'(RW'(chip_q) * RW'(CHANS_PER_CHIP)) + RW'(11) - RW'(pos_q);
	assign rd_ok   = (pos_q != WORD_POS_LAST) && (int'(rd_addr) < NUM_CHANNELS);
	assign mem_raddr = AW'(rd_addr);

	assign wr_addr  = write_addr(lane, row);
	assign wait_dec = (wait_q != 16'd0) ? wait_q - 16'd1 : 16'd0;
	assign busy     = phase_q != PH_IDLE;
	assign busy_reject = busy && (cmd == CMD_WRITE || cmd == CMD_CLEAR ||
		cmd == CMD_REFRESH || cmd == CMD_INIT);

	always_comb begin
		phase_d   = phase_q;
		clr_idx_d = clr_idx_q;
		chip_d    = chip_q;
		pos_d     = pos_q;
		pair_d    = pair_q;
		sub_d     = sub_q;
		wait_d    = wait_q;
		shift_d   = shift_q;
		clk_lv_d  = clk_lv_q;
		data_lv_d = data_lv_q;
		err       = 1'b0;
		we_item   = 1'b0;
		mem_waddr = clr_idx_q;
		mem_wdata = 16'd0;

		priority if (busy_reject) begin
			err = 1'b1;
		end else begin
			unique case (cmd)
				CMD_WRITE: begin
					if (lane > LANE_BLUE || int'(wr_addr) >= NUM_CHANNELS) begin
						err = 1'b1;
					end else begin
						we_item   = 1'b1;
						mem_waddr = AW'(wr_addr);
						mem_wdata = value;
					end
				end
				CMD_CLEAR: begin
					clr_idx_d = '0;
					phase_d   = PH_CLEAR;
				end
				CMD_REFRESH: begin
					chip_d  = CHIP_FIRST;
					pos_d   = 4'd0;
					pair_d  = 3'd0;
					sub_d   = 2'd0;
					shift_d = 16'd0;    // first word of a chip is the command word
					phase_d = PH_SHIFT;
				end
				CMD_INIT: begin
					clk_lv_d  = 1'b0;
					data_lv_d = 1'b0;
					sub_d     = 2'd0;
					pair_d    = 3'd0;
					wait_d    = BLANK_PULSES;
					phase_d   = PH_BLANK;
				end
				CMD_TICK: begin
					unique case (phase_q)
						PH_IDLE: begin
						end
						PH_CLEAR: begin
							we_item = 1'b1;
							if (clr_idx_q == CLR_LAST) begin
								clr_idx_d = '0;
								phase_d   = PH_IDLE;
							end else begin
								clr_idx_d = clr_idx_q + 1'b1;
							end
						end
						PH_SHIFT: begin
							sub_d = sub_q + 2'd1;
							unique case (sub_q)
								2'd0: data_lv_d = shift_q[15];
								2'd1: clk_lv_d  = 1'b1;
								2'd2: data_lv_d = shift_q[14];
								default: begin
									clk_lv_d = 1'b0;
									shift_d  = {shift_q[13:0], 2'b00};
									pair_d   = pair_q + 3'd1;
									if (pair_q == 3'd7) begin
										if (chip_q == '0 && pos_q == WORD_POS_LAST) begin
											phase_d = PH_LSTART;
										end else if (pos_q == WORD_POS_LAST) begin
											pos_d   = 4'd0;
											chip_d  = chip_q - 1'b1;
											shift_d = 16'd0;
										end else begin
											pos_d   = pos_q + 4'd1;
											shift_d = rd_ok_q ? mem_rdata : 16'd0;
										end
									end
								end
							endcase
						end
						PH_BLANK: begin
							if (sub_q == 2'd0) begin
								clk_lv_d = 1'b1;
								sub_d    = 2'd1;
							end else begin
								clk_lv_d = 1'b0;
								sub_d    = 2'd0;
								wait_d   = wait_dec;
								if (wait_dec == 16'd0) begin
									phase_d = PH_LSTART;
								end
							end
						end
						PH_LSTART: begin
							data_lv_d = 1'b0;
							wait_d    = latch_low;
							pair_d    = 3'd0;
							phase_d   = (latch_low == 16'd0) ? PH_LPULSE : PH_LWAIT;
						end
						PH_LWAIT: begin
							wait_d = wait_dec;
							if (wait_dec == 16'd0) begin
								phase_d = PH_LPULSE;
							end
						end
						PH_LPULSE: begin
							data_lv_d = ~pair_q[0];
							pair_d    = pair_q + 3'd1;
							if (pair_q == 3'd7) begin
								wait_d  = 16'(latch_tail);
								phase_d = (latch_tail == 8'd0) ? PH_IDLE : PH_TAIL;
							end
						end
						PH_TAIL: begin
							wait_d = wait_dec;
							if (wait_dec == 16'd0) begin
								phase_d = PH_IDLE;
							end
						end
						default: begin
						end
					endcase
				end
				default: err = 1'b1;
			endcase
		end
	end

	assign mem_we     = boot_q | (go & we_item);
	assign boot_clear = boot_q;

	assign res.pin_clk  = clk_lv_d;
	assign res.pin_data = data_lv_d;
	assign res.busy     = phase_d != PH_IDLE;
	assign res.error    = err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			boot_q    <= 1'b1;
			clr_idx_q <= '0;
			chip_q    <= '0;
			pos_q     <= 4'd0;
			pair_q    <= 3'd0;
			sub_q     <= 2'd0;
			wait_q    <= 16'd0;
			shift_q   <= 16'd0;
			clk_lv_q  <= 1'b0;
			data_lv_q <= 1'b0;
			rd_ok_q   <= 1'b0;
		end else begin
			rd_ok_q <= rd_ok;
			if (boot_q) begin
				// zero the store once after reset, one entry per cycle
				if (clr_idx_q == CLR_LAST) begin
					boot_q    <= 1'b0;
					clr_idx_q <= '0;
				end else begin
					clr_idx_q <= clr_idx_q + 1'b1;
				end
			end else if (go) begin
				phase_q   <= phase_d;
				clr_idx_q <= clr_idx_d;
				chip_q    <= chip_d;
				pos_q     <= pos_d;
				pair_q    <= pair_d;
				sub_q     <= sub_d;
				wait_q    <= wait_d;
				shift_q   <= shift_d;
				clk_lv_q  <= clk_lv_d;
				data_lv_q <= data_lv_d;
			end
		end
	end

	a_boot_idle: assert property (@(posedge clk) disable iff (!arst_n)
		boot_q |-> phase_q == PH_IDLE)
		else $error("sequence phase left idle during boot clear");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SHIFT |-> pos_q <= WORD_POS_LAST)
		else $error("word position out of range while shifting");

	a_busy_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(go && !boot_q && phase_q != PH_IDLE && (cmd == CMD_WRITE || cmd == CMD_CLEAR ||
		cmd == CMD_REFRESH || cmd == CMD_INIT)) |-> (res.error && !mem_we))
		else $error("command accepted while a sequence runs");

	a_we_source: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !boot_q) |-> go)
		else $error("store written without a request in process");

endmodule
